@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks prop at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hw/rtl/hrsp_pkg.sv @@
// Package: shared types and constants of the hex record parser.
`timescale 1ns / 1ps
package hrsp_pkg;
   localparam logic [7:0] COLON_CHAR = 8'h3A;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] TYPE_LIMIT = 8'h05;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NO_COLON  = 3'd0,
      ERR_LENGTH    = 3'd1,
      ERR_DIGIT     = 3'd2,
      ERR_TYPE      = 3'd3,
      ERR_CHECKSUM  = 3'd4,
      ERR_AFTER_EOF = 3'd5,
      ERR_NO_EOF    = 3'd6,
      ERR_SHORT     = 3'd7
   } err_type;

   typedef enum logic [1:0] {
      PH_COLON = 2'd0,
      PH_HEX   = 2'd1,
      PH_END   = 2'd2
   } phase_type;

   // Result item as it travels from the front end to the queue and out.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [31:0] byte_address;
      logic [2:0]  record_kind;
      logic [2:0]  error_code;
      logic [31:0] start_address;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
endpackage

@@ hw/rtl/hrsp_front.sv @@
// Front end: per-character decoder that classifies the stream into results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hrsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_char,
   input  logic                in_eof,
   output logic                res_valid,
   output hrsp_pkg::result_type res_data,
   input  logic                res_space
);
   hrsp_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  char_count_ff, char_count_in;
   logic [3:0]  high_nibble_ff, high_nibble_in;
   logic [7:0]  record_length_ff, record_length_in;
   logic [15:0] record_offset_ff, record_offset_in;
   logic [2:0]  type_held_ff, type_held_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [31:0] payload_word_ff, payload_word_in;
   logic [15:0] segment_base_ff, segment_base_in;
   logic [15:0] linear_base_ff, linear_base_in;
   logic [31:0] start_word_ff, start_word_in;
   logic        eof_seen_ff, eof_seen_in;
   logic        halted_ff, halted_in;
   logic [31:0] base_ff, base_in;

   logic        fire, line_end, digit_ok;
   logic [3:0]  nib;
   logic [7:0]  byte_val, di;
   logic [8:0]  idx;
   hrsp_pkg::result_type r;
   logic        rv;
   logic        fin_err;
   hrsp_pkg::err_type fin_code;

   assign in_ready = res_space;
   assign fire = in_valid && in_ready;
   assign line_end = (in_char == hrsp_pkg::CR_CHAR) || (in_char == hrsp_pkg::LF_CHAR);

   always_comb begin
      digit_ok = 1'b1;
      nib = 4'd0;
      if (in_char inside {[8'h30:8'h39]}) begin
         nib = 4'(in_char - 8'h30);
      end else if (in_char inside {[8'h41:8'h46]}) begin
         nib = 4'(in_char - 8'h37);
      end else if (in_char inside {[8'h61:8'h66]}) begin
         nib = 4'(in_char - 8'h57);
      end else begin
         digit_ok = 1'b0;
      end
   end

   assign byte_val = {high_nibble_ff, nib};
   assign idx = char_count_ff[9:1];
   assign di = 8'(idx - 9'd4);

   // Line-end checks of a complete record.
   always_comb begin
      fin_err = 1'b0;
      fin_code = hrsp_pkg::ERR_CHECKSUM;
      if (running_sum_ff != 8'd0) begin
         fin_err = 1'b1;
      end else if (((type_held_ff == 3'd2) || (type_held_ff == 3'd4))
                   && (record_length_ff < 8'd2)) begin
         fin_err = 1'b1;
         fin_code = hrsp_pkg::ERR_SHORT;
      end else if (((type_held_ff == 3'd3) || (type_held_ff == 3'd5))
                   && (record_length_ff < 8'd4)) begin
         fin_err = 1'b1;
         fin_code = hrsp_pkg::ERR_SHORT;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      char_count_in = char_count_ff;
      high_nibble_in = high_nibble_ff;
      record_length_in = record_length_ff;
      record_offset_in = record_offset_ff;
      type_held_in = type_held_ff;
      running_sum_in = running_sum_ff;
      payload_word_in = payload_word_ff;
      segment_base_in = segment_base_ff;
      linear_base_in = linear_base_ff;
      start_word_in = start_word_ff;
      eof_seen_in = eof_seen_ff;
      halted_in = halted_ff;
      base_in = base_ff;
      rv = 1'b0;
      r = '0;
      if (fire && !halted_ff) begin
         if (in_eof) begin
            rv = 1'b1;
            halted_in = 1'b1;
            if (phase_ff == hrsp_pkg::PH_HEX) begin
               r.kind = hrsp_pkg::KIND_ERROR;
               r.error_code = hrsp_pkg::ERR_LENGTH;
            end else if ((phase_ff == hrsp_pkg::PH_END) && fin_err) begin
               r.kind = hrsp_pkg::KIND_ERROR;
               r.error_code = fin_code;
            end else if (!(eof_seen_ff || ((phase_ff == hrsp_pkg::PH_END)
                                          && (type_held_ff == 3'd1)))) begin
               r.kind = hrsp_pkg::KIND_ERROR;
               r.error_code = hrsp_pkg::ERR_NO_EOF;
            end else begin
               r.kind = hrsp_pkg::KIND_DONE;
               r.start_address = ((phase_ff == hrsp_pkg::PH_END) &&
                  ((type_held_ff == 3'd3) || (type_held_ff == 3'd5)))
                  ? payload_word_ff : start_word_ff;
            end
         end else begin
            case (phase_ff)
               hrsp_pkg::PH_COLON: begin
                  if (!line_end) begin
                     if (eof_seen_ff || (in_char != hrsp_pkg::COLON_CHAR)) begin
                        rv = 1'b1;
                        halted_in = 1'b1;
                        r.kind = hrsp_pkg::KIND_ERROR;
                        r.error_code = eof_seen_ff ? hrsp_pkg::ERR_AFTER_EOF
                                                   : hrsp_pkg::ERR_NO_COLON;
                     end else begin
                        char_count_in = '0;
                        high_nibble_in = '0;
                        record_length_in = '0;
                        record_offset_in = '0;
                        type_held_in = '0;
                        running_sum_in = '0;
                        payload_word_in = '0;
                        phase_in = hrsp_pkg::PH_HEX;
                     end
                  end
               end
               hrsp_pkg::PH_END: begin
                  rv = 1'b1;
                  phase_in = hrsp_pkg::PH_COLON;
                  if (!line_end) begin
                     halted_in = 1'b1;
                     r.kind = hrsp_pkg::KIND_ERROR;
                     r.error_code = hrsp_pkg::ERR_LENGTH;
                  end else if (fin_err) begin
                     halted_in = 1'b1;
                     r.kind = hrsp_pkg::KIND_ERROR;
                     r.error_code = fin_code;
                  end else begin
                     r.kind = hrsp_pkg::KIND_ACCEPT;
                     r.record_kind = type_held_ff;
                     case (type_held_ff)
                        3'd1: eof_seen_in = 1'b1;
                        3'd2: segment_base_in = payload_word_ff[31:16];
                        3'd4: linear_base_in = payload_word_ff[31:16];
                        3'd3, 3'd5: start_word_in = payload_word_ff;
                        default: ;
                     endcase
                  end
               end
               hrsp_pkg::PH_HEX: begin
                  if (line_end || !digit_ok) begin
                     rv = 1'b1;
                     halted_in = 1'b1;
                     r.kind = hrsp_pkg::KIND_ERROR;
                     r.error_code = line_end ? hrsp_pkg::ERR_LENGTH
                                             : hrsp_pkg::ERR_DIGIT;
                  end else if (!char_count_ff[0]) begin
                     high_nibble_in = nib;
                     char_count_in = char_count_ff + 10'd1;
                  end else begin
                     char_count_in = char_count_ff + 10'd1;
                     running_sum_in = running_sum_ff + byte_val;
                     if (idx == 9'd0) begin
                        record_length_in = byte_val;
                     end else if (idx == 9'd1) begin
                        record_offset_in = {byte_val, 8'd0};
                     end else if (idx == 9'd2) begin
                        record_offset_in = {record_offset_ff[15:8], byte_val};
                        // Base for this record's data bytes, one add ahead.
                        base_in = ({16'd0, record_offset_ff[15:8], byte_val}
                                   + {12'd0, segment_base_ff, 4'd0})
                                  | {linear_base_ff, 16'd0};
                     end else if (idx == 9'd3) begin
                        if (byte_val > hrsp_pkg::TYPE_LIMIT) begin
                           rv = 1'b1;
                           halted_in = 1'b1;
                           r.kind = hrsp_pkg::KIND_ERROR;
                           r.error_code = hrsp_pkg::ERR_TYPE;
                        end else begin
                           type_held_in = byte_val[2:0];
                        end
                     end else if ((idx - 9'd4) < {1'b0, record_length_ff}) begin
                        case (di[1:0])
                           2'd0: if (di < 8'd4) payload_word_in[31:24] = byte_val;
                           2'd1: if (di < 8'd4) payload_word_in[23:16] = byte_val;
                           2'd2: if (di < 8'd4) payload_word_in[15:8] = byte_val;
                           default: if (di < 8'd4) payload_word_in[7:0] = byte_val;
                        endcase
                        if (type_held_ff == 3'd0) begin
                           rv = 1'b1;
                           r.kind = hrsp_pkg::KIND_DATA;
                           r.data_byte = byte_val;
                           r.byte_address = base_ff + {24'd0, di};
                        end
                     end else begin
                        phase_in = hrsp_pkg::PH_END;
                     end
                  end
               end
               default: phase_in = hrsp_pkg::PH_COLON;
            endcase
         end
      end
   end

   assign res_valid = rv;
   assign res_data = r;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrsp_pkg::PH_COLON;
         char_count_ff <= '0;
         high_nibble_ff <= '0;
         record_length_ff <= '0;
         record_offset_ff <= '0;
         type_held_ff <= '0;
         running_sum_ff <= '0;
         payload_word_ff <= '0;
         segment_base_ff <= '0;
         linear_base_ff <= '0;
         start_word_ff <= '0;
         eof_seen_ff <= 1'b0;
         halted_ff <= 1'b0;
         base_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         char_count_ff <= char_count_in;
         high_nibble_ff <= high_nibble_in;
         record_length_ff <= record_length_in;
         record_offset_ff <= record_offset_in;
         type_held_ff <= type_held_in;
         running_sum_ff <= running_sum_in;
         payload_word_ff <= payload_word_in;
         segment_base_ff <= segment_base_in;
         linear_base_ff <= linear_base_in;
         start_word_ff <= start_word_in;
         eof_seen_ff <= eof_seen_in;
         halted_ff <= halted_in;
         base_ff <= base_in;
      end
   end

   `ASSERT_CLK(a_halt_silent, clock, reset, halted_ff |-> !res_valid,
      "result produced while halted")
   `ASSERT_CLK(a_halt_sticky, clock, reset, halted_ff |=> halted_ff,
      "halt released without reset")
   `ASSERT_CLK(a_err_halts, clock, reset,
      (res_valid && (res_data.kind == hrsp_pkg::KIND_ERROR)) |=> halted_ff,
      "error did not halt parser")
endmodule

@@ hw/rtl/hrsp_queue.sv @@
// Back end: two-entry result queue that drives the result channel.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hrsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  hrsp_pkg::result_type wr_data,
   output logic                 wr_space,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output hrsp_pkg::result_type rd_data
);
   hrsp_pkg::result_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];
   assign pop = rd_valid && rd_ready;
   // Space is granted for a push only when a slot is free before this cycle.
   assign wr_space = cnt_ff != 2'd2;
   assign push = wr_valid && wr_space;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   `ASSERT_CLK(a_no_overflow, clock, reset, (cnt_ff == 2'd2) |-> !push,
      "push into full result queue")
   `ASSERT_CLK(a_count_track, clock, reset,
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1),
      "queue count lost a push")
endmodule

@@ hw/rtl/hex_record_stream_parser.sv @@
// Top level: Intel HEX text stream parser.
`timescale 1ns / 1ps
// Usage:
//   req_ channel carries one ASCII character per transfer; req_tlast set
//   marks end of text (the character is then ignored).
//   rsp_ channel carries one result per transfer: data bytes of data
//   records with their 32-bit address, a record-accepted status at each
//   line end, an error code, or file complete with the start address.
//   A result caused by a character is written into the result queue at the
//   character transfer. Throughput: one character per cycle while the queue
//   has space; the front-end decoder forms each result combinationally.
//   A two-entry queue sits between decoder and output; req_tready drops
//   only while that queue is full, so a stalled receiver backs up the
//   input after two held results.
//   Reset clears the decoder state, bases, start address and the queue.
//   After an error or file complete the block swallows all input without
//   results until the next reset.
module hex_record_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] data_byte, [39:8] byte_address,
                                    // [42:40] record_kind, [45:43] error_code,
                                    // [77:46] start_address, [79:78] zero
   output logic [1:0]  rsp_tuser    // [1:0] kind
);
   logic                 fr_valid, q_space;
   hrsp_pkg::result_type fr_data, q_data;

   hrsp_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_char(req_tdata), .in_eof(req_tlast),
      .res_valid(fr_valid), .res_data(fr_data), .res_space(q_space)
   );

   hrsp_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fr_valid), .wr_data(fr_data), .wr_space(q_space),
      .rd_valid(rsp_tvalid), .rd_ready(rsp_tready), .rd_data(q_data)
   );

   assign rsp_tuser = q_data.kind;
   assign rsp_tdata = {2'b00, q_data.start_address, q_data.error_code,
                       q_data.record_kind, q_data.byte_address, q_data.data_byte};

   `ASSERT_CLK(a_ready_tracks_queue, clock, reset,
      (req_tvalid && !req_tready) |-> !fr_valid,
      "decoder result while input stalled")
   `ASSERT_CLK(a_out_zero_pad, clock, reset, rsp_tvalid |-> (rsp_tdata[79:78] == 2'b00),
      "nonzero pad bits on result")
endmodule
